FILE: rtl/core/mccs_pkg.sv
package mccs_pkg;

  // Command codes carried by an input transaction.
  localparam logic [1:0] CMD_RECEIVE   = 2'd0;
  localparam logic [1:0] CMD_READ_BYTE = 2'd1;
  localparam logic [1:0] CMD_READ_PAIR = 2'd2;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;

  // Controller numbers with special handling.
  localparam logic [6:0] CC_DATA_MSB   = 7'd6;
  localparam logic [6:0] CC_DATA_LSB   = 7'd38;
  localparam logic [6:0] CC_DATA_INC   = 7'd96;
  localparam logic [6:0] CC_DATA_DEC   = 7'd97;
  localparam logic [6:0] CC_MODE_FIRST = 7'd120;
  localparam logic [6:0] CC_RESET_ALL  = 7'd121;
  localparam logic [6:0] CC_PAIR_LAST  = 7'd31;
  localparam logic [6:0] CC_PAIR_LSB   = 7'd32;
  localparam logic [6:0] CC_MASK       = 7'h7f;

  // Input and result payloads.
  typedef struct packed {
    logic [1:0] command;
    logic [6:0] control_number;
    logic [6:0] cc_value;
  } in_t;

  typedef struct packed {
    logic [13:0] read_value;
    logic        status;
  } out_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    out_t data;
  } mccs_res_t;

  // Power-on contents of the store, which an entry shows until it is written.
  function automatic logic [6:0] reset_value(input logic [6:0] idx);
    logic [6:0] v;
    v = 7'd0;
    unique case (idx)
      7'd6, 7'd38, 7'd98, 7'd99, 7'd100, 7'd101: v = CC_MASK;
      7'd7:    v = 7'd100;
      7'd10:   v = 7'd64;
      7'd11:   v = 7'd127;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // Entries that reset-all-controllers restores. Their restored values equal
  // their power-on values, so clearing the valid bit is enough.
  function automatic logic is_default(input logic [6:0] idx);
    logic d;
    d = 1'b0;
    unique case (idx)
      7'd1, 7'd6, 7'd11, 7'd38, 7'd64, 7'd65, 7'd66, 7'd67,
      7'd98, 7'd99, 7'd100, 7'd101: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/midi_control_change_store.sv
// Channel   Direction  Payload  Handshake
// in_       input      in_t     in_valid / in_stall
// out_      output     out_t    out_valid / out_stall
//
// A receive, a reset-all or a rejected read finishes on acceptance; a byte
// read reads one entry, a pair read two, a data step reads LSB then MSB and
// writes LSB, MSB and its own entry: the store has one read, one write port.
// Reset clears the per-entry valid bits; unwritten entries read as their
// power-on defaults, so no clearing pass is needed.
// A result waiting on out_stall holds the sequencer; one item may be accepted
// and finished while the previous result still sits in the output register.
module midi_control_change_store
  import mccs_pkg::*;
#(
  parameter int NUM_CONTROLS = 120
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic      out_valid_r;
  out_t      out_data_r;
  logic      out_free;
  mccs_res_t res;

  assign out_free = !out_valid_r || !out_stall;

  mccs_ctrl #(
    .NUM_CONTROLS(NUM_CONTROLS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .out_free(out_free),
    .res     (res)
  );

  // Output register separating the sequencer from the result consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res.valid) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/mccs_ram.sv
module mccs_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 120,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/mccs_ctrl.sv
module mccs_ctrl
  import mccs_pkg::*;
#(
  parameter int NUM_CONTROLS = 120
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_t       in_data,
  input  logic      out_free,
  output mccs_res_t res
);

  localparam int AW = $clog2(NUM_CONTROLS);
  localparam logic [7:0] NUM_C = 8'(NUM_CONTROLS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYTE,
    S_PAIR_HI,
    S_PAIR_LO,
    S_DE_LSB,
    S_DE_MSB,
    S_DE_WR6,
    S_DE_WRN,
    S_HOLD
  } state_t;

  state_t     state_r, state_nxt;
  logic [NUM_CONTROLS-1:0] valid_r, valid_nxt;
  logic [6:0] num_r, num_nxt;
  logic [6:0] val_r, val_nxt;
  logic [6:0] byte_r, byte_nxt;
  logic [6:0] rd_addr_q_r, rd_addr_q_nxt;
  out_t       hold_r, hold_nxt;
  mccs_res_t  res_nxt;

  logic       wr_en, rd_en;
  logic [6:0] wr_addr, rd_addr, wr_data;
  logic [6:0] rd_data, rd_val;
  logic       accept, in_range;
  logic       done;
  out_t       done_data;
  logic [7:0] lsb_inc;
  logic [6:0] lsb_dec, msb_inc, msb_dec;
  logic       lsb_zero;

  mccs_ram #(
    .WIDTH(7),
    .DEPTH(NUM_CONTROLS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr[AW-1:0]),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr[AW-1:0]),
    .rd_data(rd_data)
  );

  // An entry never written since power-on or reset-all reads as its default.
  assign rd_val = valid_r[rd_addr_q_r[AW-1:0]] ? rd_data : reset_value(rd_addr_q_r);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign in_range = ({1'b0, in_data.control_number} < NUM_C);

  // Data entry step: carry or borrow across the 7-bit LSB, MSB wraps.
  assign lsb_inc  = {1'b0, byte_r} + 8'd1;
  assign msb_inc  = rd_val + 7'(lsb_inc[7]);
  assign lsb_zero = (byte_r == 7'd0);
  assign lsb_dec  = byte_r - 7'd1;
  assign msb_dec  = rd_val - 7'(lsb_zero);

  // Sequencer: one memory access of each kind per cycle.
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    num_nxt       = num_r;
    val_nxt       = val_r;
    byte_nxt      = byte_r;
    rd_addr_q_nxt = rd_addr_q_r;
    hold_nxt      = hold_r;
    wr_en         = 1'b0;
    wr_addr       = num_r;
    wr_data       = val_r;
    rd_en         = 1'b0;
    rd_addr       = in_data.control_number;
    done          = 1'b0;
    done_data     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          num_nxt = in_data.control_number;
          val_nxt = in_data.cc_value;
          unique case (in_data.command)
            CMD_RECEIVE: begin
              if (in_data.control_number == CC_DATA_INC ||
                  in_data.control_number == CC_DATA_DEC) begin
                rd_en         = 1'b1;
                rd_addr       = CC_DATA_LSB;
                rd_addr_q_nxt = CC_DATA_LSB;
                state_nxt     = S_DE_LSB;
              end else begin
                done = 1'b1;
                if (in_range && in_data.control_number < CC_MODE_FIRST) begin
                  wr_en   = 1'b1;
                  wr_addr = in_data.control_number;
                  wr_data = in_data.cc_value;
                  valid_nxt[in_data.control_number[AW-1:0]] = 1'b1;
                end else if (in_data.control_number == CC_RESET_ALL) begin
                  for (int i = 0; i < NUM_CONTROLS; i++) begin
                    if (is_default(7'(i))) begin
                      valid_nxt[i] = 1'b0;
                    end
                  end
                end
              end
            end
            CMD_READ_BYTE: begin
              if (in_range) begin
                rd_en         = 1'b1;
                rd_addr_q_nxt = in_data.control_number;
                state_nxt     = S_BYTE;
              end else begin
                done             = 1'b1;
                done_data.status = 1'b1;
              end
            end
            CMD_READ_PAIR: begin
              if (in_data.control_number <= CC_PAIR_LAST) begin
                rd_en         = 1'b1;
                rd_addr_q_nxt = in_data.control_number;
                state_nxt     = S_PAIR_HI;
              end else begin
                done             = 1'b1;
                done_data.status = 1'b1;
              end
            end
            CMD_UNUSED: begin
              done             = 1'b1;
              done_data.status = 1'b1;
            end
            default: begin
              done             = 1'b1;
              done_data.status = 1'b1;
            end
          endcase
        end
      end
      S_BYTE: begin
        done                 = 1'b1;
        done_data.read_value = {7'd0, rd_val};
      end
      S_PAIR_HI: begin
        byte_nxt      = rd_val;
        rd_en         = 1'b1;
        rd_addr       = num_r + CC_PAIR_LSB;
        rd_addr_q_nxt = num_r + CC_PAIR_LSB;
        state_nxt     = S_PAIR_LO;
      end
      S_PAIR_LO: begin
        done                 = 1'b1;
        done_data.read_value = {byte_r, rd_val};
      end
      S_DE_LSB: begin
        byte_nxt      = rd_val;
        rd_en         = 1'b1;
        rd_addr       = CC_DATA_MSB;
        rd_addr_q_nxt = CC_DATA_MSB;
        state_nxt     = S_DE_MSB;
      end
      S_DE_MSB: begin
        // Write the stepped LSB now and keep the stepped MSB for next cycle.
        wr_en   = 1'b1;
        wr_addr = CC_DATA_LSB;
        valid_nxt[CC_DATA_LSB[AW-1:0]] = 1'b1;
        if (num_r == CC_DATA_INC) begin
          wr_data  = lsb_inc[6:0];
          byte_nxt = msb_inc;
        end else begin
          wr_data  = lsb_dec;
          byte_nxt = msb_dec;
        end
        state_nxt = S_DE_WR6;
      end
      S_DE_WR6: begin
        wr_en   = 1'b1;
        wr_addr = CC_DATA_MSB;
        wr_data = byte_r;
        valid_nxt[CC_DATA_MSB[AW-1:0]] = 1'b1;
        state_nxt = S_DE_WRN;
      end
      S_DE_WRN: begin
        wr_en   = 1'b1;
        wr_addr = num_r;
        wr_data = val_r;
        valid_nxt[num_r[AW-1:0]] = 1'b1;
        done    = 1'b1;
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A finished result goes to the output register, or waits here.
    res_nxt = '0;
    if (state_r == S_HOLD) begin
      res_nxt.valid = out_free;
      res_nxt.data  = hold_r;
    end else if (done) begin
      if (out_free) begin
        res_nxt.valid = 1'b1;
        res_nxt.data  = done_data;
        state_nxt     = S_IDLE;
      end else begin
        hold_nxt  = done_data;
        state_nxt = S_HOLD;
      end
    end
  end

  // The result is presented combinationally so the output register loads it
  // in the same cycle.
  assign res = res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    num_r       <= num_nxt;
    val_r       <= val_nxt;
    byte_r      <= byte_nxt;
    rd_addr_q_r <= rd_addr_q_nxt;
    hold_r      <= hold_nxt;
  end

endmodule

FILE: rtl/core/mccs_checker.sv
module mccs_checker
  import mccs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An unused command is answered at once with an error status.
  a_bad_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == CMD_UNUSED &&
    !(out_valid && out_stall) |=> out_valid && out_data.status &&
    out_data.read_value == 14'd0)
    else $error("unused command not rejected");

  // A plain receive is acknowledged next cycle with a zero result.
  a_receive: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == CMD_RECEIVE &&
    in_data.control_number != CC_DATA_INC &&
    in_data.control_number != CC_DATA_DEC &&
    !(out_valid && out_stall) |=> out_valid && out_data == '0)
    else $error("receive result not zero");

endmodule

bind midi_control_change_store mccs_checker u_mccs_checker (.*);
